FILE: design/tms_pkg.sv
`default_nettype none
package tms_pkg;

  localparam int TAPE_AW    = 12;
  localparam int TAPE_DEPTH = 4096;
  localparam int LEN_BITS   = 13;
  localparam int STATE_BITS = 6;
  localparam int SYM_BITS   = 8;
  localparam int RULE_AW    = STATE_BITS + SYM_BITS;
  localparam int STEP_BITS  = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 64;

  typedef enum logic [2:0] {
    CMD_LOAD_RULE = 3'd0,
    CMD_LOAD_TAPE = 3'd1,
    CMD_RESTART   = 3'd2,
    CMD_STEP      = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_RUNNING  = 3'd1,
    ST_HALTED   = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_FULL     = 3'd4,
    ST_BADADDR  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    DIR_HALT  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_SPARE = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    CFG_BLANK      = 3'd0,
    CFG_START_ST   = 3'd1,
    CFG_START_HEAD = 3'd2,
    CFG_INIT_LEN   = 3'd3,
    CFG_STEP_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] next_state;
    logic [1:0]            dir;
    logic [SYM_BITS-1:0]   wsym;
  } rule_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]   blank_symbol;
    logic [STATE_BITS-1:0] start_state;
    logic [TAPE_AW-1:0]    start_head;
    logic [LEN_BITS-1:0]   initial_length;
    logic [STEP_BITS-1:0]  step_limit;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [RULE_AW-1:0]  waddr;
    rule_t               wdata;
    logic [RULE_AW-1:0]  raddr;
  } rule_req_t;

  typedef struct packed {
    logic                we;
    logic [TAPE_AW-1:0]  waddr;
    logic [SYM_BITS-1:0] wdata;
    logic [TAPE_AW-1:0]  raddr;
  } tape_req_t;

endpackage
`default_nettype wire

FILE: design/tms_rule_mem.sv
`default_nettype none
module tms_rule_mem (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tms_pkg::rule_req_t  req,
  output tms_pkg::rule_t           rdata,
  output logic                     busy
);

  tms_pkg::rule_t mem [2**tms_pkg::RULE_AW];

  logic                        clearing;
  logic [tms_pkg::RULE_AW-1:0] clr_addr;
  logic                        wen;
  logic [tms_pkg::RULE_AW-1:0] waddr;
  tms_pkg::rule_t              wdata;

  // clearing pass fills every entry with a halt rule after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  always_comb begin
    wen   = clearing | req.we;
    waddr = clearing ? clr_addr : req.waddr;
    wdata = clearing ? '0 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[req.raddr];
  end

  assign busy = clearing;

endmodule
`default_nettype wire

FILE: design/tms_tape_mem.sv
`default_nettype none
module tms_tape_mem (
  input  wire logic                          clk,
  input  wire tms_pkg::tape_req_t            req,
  output logic [tms_pkg::SYM_BITS-1:0]       rdata
);

  logic [tms_pkg::SYM_BITS-1:0] mem [tms_pkg::TAPE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

FILE: design/tms_ctrl.sv
`default_nettype none
module tms_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tms_pkg::cfg_t                       cfg,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [tms_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  wire logic [2:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [tms_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  output logic [2:0]                               m_tuser,
  input  wire logic                                rule_busy,
  input  wire tms_pkg::rule_t                      rule_q,
  input  wire logic [tms_pkg::SYM_BITS-1:0]        tape_q,
  output tms_pkg::rule_req_t                       rule_req,
  output tms_pkg::tape_req_t                       tape_req
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ISSUE  = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_APPLY  = 6'b001000,
    S_BLANK  = 6'b010000,
    S_FIN    = 6'b100000
  } fsm_t;

  fsm_t fsm, fsm_next;

  // latched item
  logic [2:0]                      cmd;
  logic [tms_pkg::STATE_BITS-1:0]  rule_state;
  logic [tms_pkg::SYM_BITS-1:0]    rule_symbol;
  logic [tms_pkg::SYM_BITS-1:0]    write_symbol;
  logic [1:0]                      move_dir;
  logic [tms_pkg::STATE_BITS-1:0]  next_state;
  logic [tms_pkg::TAPE_AW-1:0]     cell_address;

  // machine state
  logic [tms_pkg::TAPE_AW-1:0]     left_end,   left_end_next;
  logic [tms_pkg::TAPE_AW-1:0]     head,       head_next;
  logic [tms_pkg::LEN_BITS-1:0]    length,     length_next;
  logic [tms_pkg::STATE_BITS-1:0]  cur_state,  cur_state_next;
  logic [tms_pkg::STEP_BITS-1:0]   steps,      steps_next;
  logic                            halted,     halted_next;

  logic [2:0]                      status,     status_next;
  logic [tms_pkg::SYM_BITS-1:0]    sym,        sym_next;

  logic                            in_acc;
  logic                            out_free;
  logic [tms_pkg::LEN_BITS-1:0]    restart_len;
  logic [tms_pkg::TAPE_AW-1:0]     restart_head;
  logic                            tape_full;
  logic                            at_right;

  assign s_tready = (fsm == S_IDLE) && !rule_busy;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (cfg.initial_length == '0)
      restart_len = tms_pkg::LEN_BITS'(1);
    else if (cfg.initial_length > tms_pkg::LEN_BITS'(tms_pkg::TAPE_DEPTH))
      restart_len = tms_pkg::LEN_BITS'(tms_pkg::TAPE_DEPTH);
    else
      restart_len = cfg.initial_length;
    if ({1'b0, cfg.start_head} < restart_len)
      restart_head = cfg.start_head;
    else
      restart_head = tms_pkg::TAPE_AW'(restart_len - 1'b1);
  end

  assign tape_full = length >= tms_pkg::LEN_BITS'(tms_pkg::TAPE_DEPTH);
  assign at_right  = ({1'b0, head} + 1'b1) >= length;

  // memory addresses: ring offset plus position relative to the left end
  always_comb begin
    rule_req.we    = 1'b0;
    rule_req.waddr = {rule_state, rule_symbol};
    rule_req.wdata = '{next_state: next_state, dir: move_dir, wsym: write_symbol};
    rule_req.raddr = {cur_state, tape_q};
    tape_req.we    = 1'b0;
    tape_req.waddr = left_end + ((fsm == S_ISSUE) ? cell_address : head);
    tape_req.wdata = rule_q.wsym;
    tape_req.raddr = left_end + ((cmd == tms_pkg::CMD_READ) ? cell_address : head);

    fsm_next       = fsm;
    left_end_next  = left_end;
    head_next      = head;
    length_next    = length;
    cur_state_next = cur_state;
    steps_next     = steps;
    halted_next    = halted;
    status_next    = status;
    sym_next       = sym;

    case (fsm)
      S_IDLE: begin
        if (in_acc) fsm_next = S_ISSUE;
      end
      S_ISSUE: begin
        status_next = tms_pkg::ST_DONE;
        sym_next    = '0;
        fsm_next    = S_FIN;
        case (cmd)
          tms_pkg::CMD_LOAD_RULE: rule_req.we = 1'b1;
          tms_pkg::CMD_LOAD_TAPE: begin
            tape_req.we    = 1'b1;
            tape_req.wdata = rule_symbol;
          end
          tms_pkg::CMD_RESTART: begin
            left_end_next  = '0;
            length_next    = restart_len;
            head_next      = restart_head;
            cur_state_next = cfg.start_state;
            steps_next     = '0;
            halted_next    = 1'b0;
          end
          tms_pkg::CMD_STEP: begin
            if (halted)
              status_next = tms_pkg::ST_HALTED;
            else if (steps >= cfg.step_limit)
              status_next = tms_pkg::ST_LIMIT;
            else
              fsm_next = S_LOOKUP;
          end
          tms_pkg::CMD_READ: begin
            if ({1'b0, cell_address} < length)
              fsm_next = S_LOOKUP;
            else
              status_next = tms_pkg::ST_BADADDR;
          end
          default: ;
        endcase
      end
      S_LOOKUP: begin
        // tape data is back; a read ends here, a step looks up its rule
        if (cmd == tms_pkg::CMD_READ) begin
          sym_next = tape_q;
          fsm_next = S_FIN;
        end else begin
          fsm_next = S_APPLY;
        end
      end
      S_APPLY: begin
        fsm_next = S_FIN;
        if (rule_q.dir != tms_pkg::DIR_LEFT && rule_q.dir != tms_pkg::DIR_RIGHT) begin
          halted_next = 1'b1;
          status_next = tms_pkg::ST_HALTED;
        end else if (((rule_q.dir == tms_pkg::DIR_LEFT) && (head == '0) ||
                      (rule_q.dir == tms_pkg::DIR_RIGHT) && at_right) && tape_full) begin
          halted_next = 1'b1;
          status_next = tms_pkg::ST_FULL;
        end else begin
          tape_req.we    = 1'b1;
          cur_state_next = rule_q.next_state;
          steps_next     = steps + 1'b1;
          sym_next       = rule_q.wsym;
          status_next    = tms_pkg::ST_RUNNING;
          if (rule_q.dir == tms_pkg::DIR_LEFT) begin
            if (head == '0) begin
              left_end_next = left_end - 1'b1;
              length_next   = length + 1'b1;
              fsm_next      = S_BLANK;
            end else begin
              head_next = head - 1'b1;
            end
          end else begin
            head_next = head + 1'b1;
            if (at_right) begin
              length_next = length + 1'b1;
              fsm_next    = S_BLANK;
            end
          end
        end
      end
      S_BLANK: begin
        // new end cell sits at left_end + head in both directions
        tape_req.we    = 1'b1;
        tape_req.wdata = cfg.blank_symbol;
        fsm_next       = S_FIN;
      end
      S_FIN: begin
        if (out_free) fsm_next = S_IDLE;
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      left_end  <= '0;
      head      <= '0;
      length    <= tms_pkg::LEN_BITS'(1);
      cur_state <= '0;
      steps     <= '0;
      halted    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      fsm       <= fsm_next;
      left_end  <= left_end_next;
      head      <= head_next;
      length    <= length_next;
      cur_state <= cur_state_next;
      steps     <= steps_next;
      halted    <= halted_next;
      if (fsm == S_FIN && out_free)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    sym    <= sym_next;
    if (in_acc) begin
      cmd          <= s_tuser;
      rule_state   <= s_tdata[5:0];
      rule_symbol  <= s_tdata[13:6];
      write_symbol <= s_tdata[21:14];
      move_dir     <= s_tdata[23:22];
      next_state   <= s_tdata[29:24];
      cell_address <= s_tdata[41:30];
    end
    if (fsm == S_FIN && out_free) begin
      m_tuser <= status;
      m_tdata <= {1'b0, steps, length, sym, cur_state, head};
    end
  end

endmodule
`default_nettype wire

FILE: design/turing_machine_step.sv
`default_nettype none
// Single-tape Turing machine engine. Each input beat carries one command in
// s_tuser (load rule, load tape cell, restart, step, read cell) and yields one
// result beat with a status in m_tuser and the head, state, symbol, tape length
// and step count after the command. Rules live in a 16384-entry memory indexed
// by state and symbol; the tape is a 4096-cell ring memory whose left end moves
// so the tape can grow at either end. After reset a clearing pass sets every
// rule to halt; no beat is taken until it ends, though configuration writes
// are. Loads, restart, refused steps, unknown commands and out-of-range reads
// finish in the issue state, an in-range read also waits for the tape data,
// and a step reads the tape, then the rule memory with that symbol, then
// writes the tape; an added end cell needs a second write through the single
// tape write port. A new beat is taken only in the idle state, and a result
// held back by the output side stalls the next beat until it is taken.
module turing_machine_step (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  // rule_state, rule_symbol, write_symbol, move_dir, next_state, cell_address
  input  wire logic [tms_pkg::IN_DATA_BITS-1:0]         s_tdata,
  // cmd
  input  wire logic [2:0]                               s_tuser,
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  // head position, machine_state, cell_symbol, tape_length, step_count
  output logic [tms_pkg::OUT_DATA_BITS-1:0]             m_tdata,
  // status
  output logic [2:0]                                    m_tuser,
  input  wire logic                                     cfg_we,
  input  wire logic [tms_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  wire logic [tms_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  tms_pkg::cfg_t      cfg;
  tms_pkg::rule_req_t rule_req;
  tms_pkg::tape_req_t tape_req;
  tms_pkg::rule_t     rule_q;
  logic [tms_pkg::SYM_BITS-1:0] tape_q;
  logic               rule_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blank_symbol   <= '0;
      cfg.start_state    <= '0;
      cfg.start_head     <= '0;
      cfg.initial_length <= tms_pkg::LEN_BITS'(1);
      cfg.step_limit     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tms_pkg::CFG_BLANK:      cfg.blank_symbol   <= cfg_data[tms_pkg::SYM_BITS-1:0];
        tms_pkg::CFG_START_ST:   cfg.start_state    <= cfg_data[tms_pkg::STATE_BITS-1:0];
        tms_pkg::CFG_START_HEAD: cfg.start_head     <= cfg_data[tms_pkg::TAPE_AW-1:0];
        tms_pkg::CFG_INIT_LEN:   cfg.initial_length <= cfg_data[tms_pkg::LEN_BITS-1:0];
        tms_pkg::CFG_STEP_LIMIT: cfg.step_limit     <= cfg_data[tms_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  tms_rule_mem u_rule_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (rule_req),
    .rdata (rule_q),
    .busy  (rule_busy)
  );

  tms_tape_mem u_tape_mem (
    .clk   (clk),
    .req   (tape_req),
    .rdata (tape_q)
  );

  tms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .rule_busy (rule_busy),
    .rule_q    (rule_q),
    .tape_q    (tape_q),
    .rule_req  (rule_req),
    .tape_req  (tape_req)
  );

endmodule
`default_nettype wire
